@@ hdl/rtoe_pkg.sv @@
// rtoe_pkg: shared constants and types for the rto estimator with backoff
// no dependencies; used by rto_estimator_with_backoff_top
`default_nettype none

package rtoe_pkg;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_BACKOFF = 2'd1;
   localparam logic [1:0] CMD_INIT    = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_MIN_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_MAX_TIMEOUT  = 2'd1;
   localparam logic [1:0] REG_INIT_TIMEOUT = 2'd2;

   // reset values of the configuration registers and the timeout
   localparam logic [15:0] MIN_TIMEOUT_RST  = 16'd100;
   localparam logic [15:0] MAX_TIMEOUT_RST  = 16'd5000;
   localparam logic [15:0] INIT_TIMEOUT_RST = 16'd500;

   // timer tick length in ms, range 1 to 1024
   localparam int unsigned TICK_MS = 16;

   // floor on the variance term, 10 ms in Q18.4
   localparam logic [21:0] SPREAD_FLOOR = 22'd160;

   // largest tick count that the delay field can show
   localparam logic [15:0] TICKS_MAX = 16'd4095;

   // one result word before packing
   typedef struct packed {
      logic [19:0] rtt_variance;
      logic [19:0] smoothed_rtt;
      logic [11:0] delay_ticks;
      logic [15:0] timeout_ms;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/rto_estimator_with_backoff_top.sv @@
// Retransmission timeout estimator with backoff: smoothed rtt, rtt variance
// and timeout update in one pass per word. Depends on rtoe_pkg.
//
// Usage:
//   req channel: req_tuser carries the command (sample, backoff, init),
//   req_tdata the measured round trip in ms. Every accepted word gives one
//   rsp word with the timeout, the timer delay in ticks and both estimates
//   after that word.
//   csr port: csr_we writes csr_wdata to register csr_addr (0 min timeout,
//   1 max timeout, 2 initial timeout) in the same cycle; other indexes are
//   ignored. Write only while no word is in flight.
// Flow and throughput:
//   a word accepted into the input register is processed against the state
//   registers and its result is written to the result register, which
//   drives rsp_tvalid. One word per cycle is sustained while rsp_tready is
//   high; the state update is a combinational shift-and-add path, so each
//   word sees the state left by the word before it.
// Reset: clears both estimates, loads the timeout with 500 ms and the
//   configuration registers with 100, 5000 and 500 ms; both stages empty.
// Stall: while rsp_tready is low the result register holds and the input
//   register keeps one more word, then req_tready drops.
`default_nettype none

module rto_estimator_with_backoff_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample_ms
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [15:0] timeout_ms, [27:16] delay_ticks,
                                         // [47:28] smoothed_rtt, [67:48] rtt_variance,
                                         // [71:68] zero
   // configuration port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [15:0] min_to_ff, max_to_ff, init_to_ff;

   // input stage
   logic        in_vld_ff;
   logic [1:0]  cmd_ff;
   logic [15:0] sample_ff;

   // estimator state
   logic [19:0] srtt_ff, srtt_in;
   logic [19:0] rttvar_ff, rttvar_in;
   logic [15:0] rto_ff, rto_in;

   // output stage
   logic                 out_vld_ff;
   rtoe_pkg::result_type res_ff, res_in;

   logic advance;

   // sample path
   logic [19:0] s_q;
   logic [19:0] diff;
   logic [21:0] var_sum;
   logic [22:0] srtt_sum;
   logic [19:0] srtt_new, rttvar_new;
   logic [21:0] spread;
   logic [22:0] total;
   logic [18:0] t_ms;
   logic [18:0] t_hi;
   logic [15:0] t_clamp;
   logic [16:0] doubled;
   logic [15:0] backoff;
   logic [15:0] quo;
   logic [11:0] ticks;

   // handshake: the input stage moves on when the result register is free
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, res_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_to_ff  <= rtoe_pkg::MIN_TIMEOUT_RST;
         max_to_ff  <= rtoe_pkg::MAX_TIMEOUT_RST;
         init_to_ff <= rtoe_pkg::INIT_TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            rtoe_pkg::REG_MIN_TIMEOUT:  min_to_ff  <= csr_wdata;
            rtoe_pkg::REG_MAX_TIMEOUT:  max_to_ff  <= csr_wdata;
            rtoe_pkg::REG_INIT_TIMEOUT: init_to_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff    <= req_tuser;
         sample_ff <= req_tdata;
      end
   end

   // sample update: variance uses the old srtt
   always_comb begin
      s_q      = {sample_ff, 4'd0};
      diff     = (srtt_ff >= s_q) ? (srtt_ff - s_q) : (s_q - srtt_ff);
      var_sum  = 22'(rttvar_ff) + {1'b0, rttvar_ff, 1'b0} + 22'(diff);
      srtt_sum = {srtt_ff, 3'd0} - 23'(srtt_ff) + 23'(s_q);
      if (srtt_ff == 20'd0) begin
         srtt_new   = s_q;
         rttvar_new = {1'b0, s_q[19:1]};
      end else begin
         srtt_new   = srtt_sum[22:3];
         rttvar_new = var_sum[21:2];
      end
      // timeout from the new estimates, clamped, minimum applied last
      spread  = {rttvar_new, 2'd0};
      if (spread < rtoe_pkg::SPREAD_FLOOR) begin
         spread = rtoe_pkg::SPREAD_FLOOR;
      end
      total   = 23'(srtt_new) + 23'(spread);
      t_ms    = total[22:4];
      t_hi    = (t_ms > 19'(max_to_ff)) ? 19'(max_to_ff) : t_ms;
      t_clamp = (t_hi < 19'(min_to_ff)) ? min_to_ff : t_hi[15:0];
      // exponential backoff capped at the maximum
      doubled = {rto_ff, 1'b0};
      backoff = (doubled > 17'(max_to_ff)) ? max_to_ff : doubled[15:0];
   end

   // command select
   always_comb begin
      srtt_in   = srtt_ff;
      rttvar_in = rttvar_ff;
      rto_in    = rto_ff;
      unique case (cmd_ff)
         rtoe_pkg::CMD_SAMPLE: begin
            srtt_in   = srtt_new;
            rttvar_in = rttvar_new;
            rto_in    = t_clamp;
         end
         rtoe_pkg::CMD_BACKOFF: begin
            rto_in = backoff;
         end
         rtoe_pkg::CMD_INIT: begin
            srtt_in   = 20'd0;
            rttvar_in = 20'd0;
            rto_in    = init_to_ff;
         end
         default: ;
      endcase
   end

   // timer delay: quotient by the tick length, kept in 1 to 4095
   always_comb begin
      quo = rto_in / 16'(rtoe_pkg::TICK_MS);
      if (quo > rtoe_pkg::TICKS_MAX) begin
         ticks = rtoe_pkg::TICKS_MAX[11:0];
      end else if (quo == 16'd0) begin
         ticks = 12'd1;
      end else begin
         ticks = quo[11:0];
      end
      res_in.timeout_ms   = rto_in;
      res_in.delay_ticks  = ticks;
      res_in.smoothed_rtt = srtt_in;
      res_in.rtt_variance = rttvar_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff   <= 20'd0;
         rttvar_ff <= 20'd0;
         rto_ff    <= rtoe_pkg::INIT_TIMEOUT_RST;
      end else if (advance) begin
         srtt_ff   <= srtt_in;
         rttvar_ff <= rttvar_in;
         rto_ff    <= rto_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

@@ sim/rto_estimator_with_backoff_top_test.sv @@
`timescale 1ns / 1ps
// testbench for rto_estimator_with_backoff_top: sends command words and csr writes,
// predicts every response word and checks it field by field
// depends on rtoe_pkg and rto_estimator_with_backoff_top

module rto_estimator_with_backoff_top_test;

   // command and register codes that the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   // estimator state and registers as the block should hold them
   logic [19:0] est_srtt   = '0;
   logic [19:0] est_rttvar = '0;
   logic [15:0] est_rto    = rtoe_pkg::INIT_TIMEOUT_RST;
   logic [15:0] cfg_min    = rtoe_pkg::MIN_TIMEOUT_RST;
   logic [15:0] cfg_max    = rtoe_pkg::MAX_TIMEOUT_RST;
   logic [15:0] cfg_init   = rtoe_pkg::INIT_TIMEOUT_RST;

   rtoe_pkg::result_type expected_words[$];
   rtoe_pkg::result_type want_word;
   rtoe_pkg::result_type seen_word;
   int         errors      = 0;
   bit         idle_on     = 1'b1;
   int         hold_cycles = 0;
   int         sample_base = 200;

   rto_estimator_with_backoff_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // next estimator state and the response word it reports
   function automatic rtoe_pkg::result_type advance_estimator(input logic [1:0] cmd,
                                                              input logic [15:0] sample);
      int unsigned scaled;
      int unsigned gap;
      int unsigned spread;
      int unsigned total;
      rtoe_pkg::result_type word;
      scaled = int'(sample) << 4;
      case (cmd)
         rtoe_pkg::CMD_SAMPLE: begin
            if (est_srtt == '0) begin
               // no estimate yet: take the sample, variance half of it
               est_rttvar = 20'(scaled >> 1);
               est_srtt   = 20'(scaled);
            end else begin
               // variance moves toward the error against the old srtt
               gap        = (est_srtt >= scaled) ? est_srtt - scaled : scaled - est_srtt;
               est_rttvar = 20'((3 * est_rttvar + gap) >> 2);
               est_srtt   = 20'((7 * est_srtt + scaled) >> 3);
            end
            spread = 4 * est_rttvar;
            if (spread < rtoe_pkg::SPREAD_FLOOR) spread = rtoe_pkg::SPREAD_FLOOR;
            total = (est_srtt + spread) >> 4;
            // minimum clamp last, so it wins over the maximum
            if (total > cfg_max) total = cfg_max;
            if (total < cfg_min) total = cfg_min;
            est_rto = 16'(total);
         end
         rtoe_pkg::CMD_BACKOFF: begin
            total = 2 * est_rto;
            if (total > cfg_max) total = cfg_max;
            est_rto = 16'(total);
         end
         rtoe_pkg::CMD_INIT: begin
            est_srtt   = '0;
            est_rttvar = '0;
            est_rto    = cfg_init;
         end
         default: ;  // unused command leaves the state alone
      endcase
      total = est_rto / rtoe_pkg::TICK_MS;
      if (total < 1) total = 1;
      if (total > rtoe_pkg::TICKS_MAX) total = rtoe_pkg::TICKS_MAX;
      word.timeout_ms   = est_rto;
      word.delay_ticks  = 12'(total);
      word.smoothed_rtt = est_srtt;
      word.rtt_variance = est_rttvar;
      return word;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 74) return rtoe_pkg::CMD_SAMPLE;
      if (r < 88) return rtoe_pkg::CMD_BACKOFF;
      if (r < 95) return rtoe_pkg::CMD_INIT;
      return CMD_UNUSED;
   endfunction

   // rtt samples cluster around a per-phase base, with extremes and noise
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 16'($urandom_range(sample_base / 2, sample_base + sample_base / 2));
      if (r < 75) begin
         case ($urandom_range(0, 2))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'hffff;
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // offer one word, wait for the handshake, record the expected response
   task automatic send_word(input logic [1:0] cmd, input logic [15:0] sample);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(advance_estimator(cmd, sample));
   endtask

   // stop sending until every response is back and the pipe is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all three registers plus the unused index, block idle
   task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] start);
      logic [15:0] values[4];
      logic [1:0]  addrs[4];
      wait_idle();
      values = '{lo, hi, start, 16'($urandom)};
      addrs  = '{rtoe_pkg::REG_MIN_TIMEOUT, rtoe_pkg::REG_MAX_TIMEOUT,
                 rtoe_pkg::REG_INIT_TIMEOUT, REG_UNUSED};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= addrs[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we   <= 1'b0;
      cfg_min  = lo;
      cfg_max  = hi;
      cfg_init = start;
   endtask

   // zero and full-scale samples, every command, at reset settings
   task automatic test_first_samples();
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd0);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'hffff);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'hffff);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd0);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'hffff);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'd0);
      send_word(CMD_UNUSED, 16'h5a5a);
      send_word(rtoe_pkg::CMD_INIT, 16'hffff);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'd0);
   endtask

   // srtt decays to zero under zero samples, next sample counts as a first one
   task automatic test_srtt_decay();
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd1);
      repeat (12) send_word(rtoe_pkg::CMD_SAMPLE, 16'd0);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd300);
   endtask

   // minimum above maximum, smallest maximum, everything at full scale
   task automatic test_clamp_extremes();
      set_config(16'd3000, 16'd200, 16'hffff);
      send_word(rtoe_pkg::CMD_INIT, 16'd0);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'd0);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd10);
      set_config(16'd0, 16'd1, 16'd1);
      send_word(rtoe_pkg::CMD_INIT, 16'd0);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'd0);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'd0);
      set_config(16'hffff, 16'hffff, 16'hffff);
      send_word(rtoe_pkg::CMD_INIT, 16'd0);
      send_word(rtoe_pkg::CMD_BACKOFF, 16'd0);
      send_word(rtoe_pkg::CMD_SAMPLE, 16'hffff);
   endtask

   // receiver holds off while words keep coming, then the sender drains
   task automatic test_backpressure();
      set_config(rtoe_pkg::MIN_TIMEOUT_RST, rtoe_pkg::MAX_TIMEOUT_RST,
                 rtoe_pkg::INIT_TIMEOUT_RST);
      idle_on     = 1'b0;
      hold_cycles = 60;
      repeat (24) send_word(pick_cmd(), pick_sample());
      wait_idle();
      idle_on = 1'b1;
   endtask

   // random sessions under several settings
   task automatic test_random_phases();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(rtoe_pkg::MIN_TIMEOUT_RST, rtoe_pkg::MAX_TIMEOUT_RST,
                          rtoe_pkg::INIT_TIMEOUT_RST);
            1: set_config(16'($urandom_range(0, 500)), 16'($urandom_range(1000, 20000)),
                          16'($urandom_range(1, 3000)));
            2: set_config(16'($urandom_range(2000, 65535)), 16'($urandom_range(1, 1999)),
                          16'($urandom_range(1, 65535)));
            3: set_config(16'd0, 16'hffff, 16'hffff);
            4: set_config(16'hffff, 16'd1, 16'd1);
            default: set_config(16'($urandom), 16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 65535)));
         endcase
         sample_base = $urandom_range(1, (phase == 3) ? 40000 : 3000);
         send_word(rtoe_pkg::CMD_INIT, 16'($urandom));
         for (int i = 0; i < 100; i++) begin
            if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_word(pick_cmd(), pick_sample());
         end
      end
      idle_on = 1'b1;
   endtask

   // response side: long hold on request, otherwise random stalls
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // compare each response word with the oldest expectation
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         seen_word = rtoe_pkg::result_type'(rsp_tdata[67:0]);
         if (expected_words.size() == 0) begin
            $display("%0t ns: response word with none expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want_word = expected_words.pop_front();
            check_field("timeout_ms", want_word.timeout_ms, seen_word.timeout_ms);
            check_field("delay_ticks", want_word.delay_ticks, seen_word.delay_ticks);
            check_field("smoothed_rtt", want_word.smoothed_rtt, seen_word.smoothed_rtt);
            check_field("rtt_variance", want_word.rtt_variance, seen_word.rtt_variance);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_first_samples();
      test_srtt_decay();
      test_clamp_extremes();
      test_backpressure();
      test_random_phases();
      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/rtoe_pkg.sv
hdl/rto_estimator_with_backoff_top.sv
sim/rto_estimator_with_backoff_top_test.sv
